// ===== sv/ldps_pkg.sv =====
// Shared types and constants for the positive linear Diophantine solver.
`default_nettype none
package ldps_pkg;

  localparam int unsigned AmountW = 31;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned ScaleW  = 20;
  localparam int unsigned RValW   = 40;
  localparam int unsigned SValW   = 53;
  localparam int unsigned DivW    = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_COEF_X = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_COEF_Y = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SCALE  = 2'd2;

  localparam logic CMD_PREPARE = 1'b0;
  localparam logic CMD_SOLVE   = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_NO_SOLUTION  = 2'd1,
    STATUS_TOO_LARGE    = 2'd2,
    STATUS_NOT_PREPARED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CLS_PREP     = 2'd0,
    CLS_PREP_BAD = 2'd1,
    CLS_SOLVE    = 2'd2
  } cls_e;

  typedef struct packed {
    cls_e               cls;
    logic [AmountW-1:0] amount;
  } q_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD_CHK,
    ST_GCD_DIV,
    ST_DIV_B,
    ST_DIV_A,
    ST_DIV_AM,
    ST_FILL,
    ST_DIV_C,
    ST_DIV_IDX,
    ST_RD,
    ST_AR,
    ST_SUB,
    ST_DIV_S,
    ST_SCL,
    ST_OUT
  } back_state_e;

endpackage
`default_nettype wire

// ===== sv/ldps_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module ldps_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== sv/ldps_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module ldps_div #(
  parameter int unsigned DVW = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [ldps_pkg::DivW-1:0] dividend_i,
  input  wire logic [DVW-1:0]            divisor_i,
  output logic                           done_o,
  output logic      [ldps_pkg::DivW-1:0] quo_o,
  output logic      [DVW-1:0]            rem_o
);

  localparam int unsigned CntW = $clog2(ldps_pkg::DivW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [ldps_pkg::DivW-1:0] quo_q, quo_d;
  logic [DVW-1:0]  rem_q, rem_d;
  logic [DVW-1:0]  dsr_q, dsr_d;
  logic [DVW:0]    shifted;
  logic [DVW:0]    trial;

  assign shifted = {rem_q, quo_q[ldps_pkg::DivW-1]};
  assign trial   = shifted - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (trial[DVW]) begin
        rem_d = shifted[DVW-1:0];
        quo_d = {quo_q[ldps_pkg::DivW-2:0], 1'b0};
      end else begin
        rem_d = trial[DVW-1:0];
        quo_d = {quo_q[ldps_pkg::DivW-2:0], 1'b1};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(ldps_pkg::DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ===== sv/ldps_front.sv =====
// Input acceptance, command classification and a two-entry queue to the back end.
`default_nettype none
module ldps_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         cmd_i,
  input  wire logic [ldps_pkg::AmountW-1:0] amount_i,
  input  wire logic [ldps_pkg::CoefW-1:0]   coef_x_i,
  input  wire logic [ldps_pkg::CoefW-1:0]   coef_y_i,
  output logic                              q_valid_o,
  output ldps_pkg::q_entry_t                q_head_o,
  input  wire logic                         q_pop_i
);

  ldps_pkg::q_entry_t entry_q [2];
  ldps_pkg::q_entry_t new_entry;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push;

  always_comb begin
    new_entry.amount = amount_i;
    if (cmd_i == ldps_pkg::CMD_SOLVE) begin
      new_entry.cls = ldps_pkg::CLS_SOLVE;
    end else if (coef_x_i == '0 || coef_y_i == '0) begin
      new_entry.cls = ldps_pkg::CLS_PREP_BAD;
    end else begin
      new_entry.cls = ldps_pkg::CLS_PREP;
    end
  end

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_head_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_entry;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ldps_back.sv =====
// Back end: prepare and solve sequencer around a shared divider and the residue table.
`default_nettype none
module ldps_back #(
  parameter int unsigned MAX_MODULUS = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         q_valid_i,
  input  wire ldps_pkg::q_entry_t           q_head_i,
  output logic                              q_pop_o,
  input  wire logic [ldps_pkg::CoefW-1:0]   coef_x_i,
  input  wire logic [ldps_pkg::CoefW-1:0]   coef_y_i,
  input  wire logic [ldps_pkg::ScaleW-1:0]  scale_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [1:0]                   status_o,
  output logic      [ldps_pkg::RValW-1:0]   r_value_o,
  output logic      [ldps_pkg::SValW-1:0]   s_value_o
);

  localparam int unsigned BW  = $clog2(MAX_MODULUS + 1);
  localparam int unsigned AW  = $clog2(MAX_MODULUS);
  localparam int unsigned DVW = (BW > ldps_pkg::CoefW) ? BW : ldps_pkg::CoefW;
  localparam int unsigned PW  = ldps_pkg::CoefW + BW;
  localparam int unsigned CW  = ((PW > ldps_pkg::AmountW) ? PW : ldps_pkg::AmountW) + 1;
  localparam logic [ldps_pkg::DivW-1:0] MaxMod = ldps_pkg::DivW'(MAX_MODULUS);

  ldps_pkg::back_state_e state_q, state_d;

  logic [ldps_pkg::CoefW-1:0]   p_q, q_q, g_q, a_q;
  logic [BW-1:0]                b_q, step_q, i_q, r_q;
  logic [AW-1:0]                res_q, rd_addr_q;
  logic [ldps_pkg::AmountW-1:0] c_q, s_q;
  logic [PW-1:0]                prod_q;
  logic [ldps_pkg::RValW-1:0]   rs_q;
  logic [ldps_pkg::SValW-1:0]   ss_q;
  ldps_pkg::status_e            res_status_q;
  logic                         prepared_q;
  logic                         out_valid_q;
  logic [1:0]                   status_out_q;
  logic [ldps_pkg::RValW-1:0]   r_out_q;
  logic [ldps_pkg::SValW-1:0]   s_out_q;

  logic                         div_start, div_done;
  logic [ldps_pkg::DivW-1:0]    div_dividend, div_quo;
  logic [DVW-1:0]               div_divisor, div_rem;
  logic                         ram_we;
  logic [BW-1:0]                ram_rdata;
  logic [BW:0]                  res_sum;
  logic [CW-1:0]                c_ext, prod_ext, diff;
  logic                         out_free;
  logic [BW+ldps_pkg::ScaleW-1:0]               r_scaled;
  logic [ldps_pkg::AmountW+ldps_pkg::ScaleW-1:0] s_scaled;

  assign res_sum  = {1'b0, BW'(res_q)} + {1'b0, step_q};
  assign c_ext    = CW'(c_q);
  assign prod_ext = CW'(prod_q);
  assign diff     = c_ext - prod_ext;
  assign out_free = !out_valid_q || out_ready_i;
  assign r_scaled = r_q * scale_i;
  assign s_scaled = s_q * scale_i;

  ldps_div #(.DVW(DVW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  ldps_ram #(.WIDTH(BW), .DEPTH(MAX_MODULUS)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (res_q),
    .wdata_i (i_q),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ldps_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          case (q_head_i.cls)
            ldps_pkg::CLS_PREP:  state_d = ldps_pkg::ST_GCD_CHK;
            ldps_pkg::CLS_SOLVE: state_d = prepared_q ? ldps_pkg::ST_DIV_C : ldps_pkg::ST_OUT;
            default:             state_d = ldps_pkg::ST_OUT;
          endcase
        end
      end
      ldps_pkg::ST_GCD_CHK: begin
        state_d = (q_q == '0) ? ldps_pkg::ST_DIV_B : ldps_pkg::ST_GCD_DIV;
      end
      ldps_pkg::ST_GCD_DIV: if (div_done) state_d = ldps_pkg::ST_GCD_CHK;
      ldps_pkg::ST_DIV_B: begin
        if (div_done) begin
          state_d = (div_quo > MaxMod) ? ldps_pkg::ST_OUT : ldps_pkg::ST_DIV_A;
        end
      end
      ldps_pkg::ST_DIV_A:  if (div_done) state_d = ldps_pkg::ST_DIV_AM;
      ldps_pkg::ST_DIV_AM: if (div_done) state_d = ldps_pkg::ST_FILL;
      ldps_pkg::ST_FILL:   if (i_q == b_q) state_d = ldps_pkg::ST_OUT;
      ldps_pkg::ST_DIV_C: begin
        if (div_done) begin
          state_d = (div_rem != '0) ? ldps_pkg::ST_OUT : ldps_pkg::ST_DIV_IDX;
        end
      end
      ldps_pkg::ST_DIV_IDX: if (div_done) state_d = ldps_pkg::ST_RD;
      ldps_pkg::ST_RD:      state_d = ldps_pkg::ST_AR;
      ldps_pkg::ST_AR:      state_d = ldps_pkg::ST_SUB;
      ldps_pkg::ST_SUB: begin
        state_d = (diff[CW-1] || diff == '0) ? ldps_pkg::ST_OUT : ldps_pkg::ST_DIV_S;
      end
      ldps_pkg::ST_DIV_S: if (div_done) state_d = ldps_pkg::ST_SCL;
      ldps_pkg::ST_SCL:   state_d = ldps_pkg::ST_OUT;
      ldps_pkg::ST_OUT:   if (out_free) state_d = ldps_pkg::ST_IDLE;
      default:            state_d = ldps_pkg::ST_IDLE;
    endcase
  end

  // Control outputs: queue pop, divider launch and operands, table write.
  always_comb begin
    q_pop_o      = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    ram_we       = 1'b0;
    case (state_q)
      ldps_pkg::ST_IDLE: begin
        q_pop_o = q_valid_i;
        if (q_valid_i && q_head_i.cls == ldps_pkg::CLS_SOLVE && prepared_q) begin
          div_start    = 1'b1;
          div_dividend = ldps_pkg::DivW'(q_head_i.amount);
          div_divisor  = DVW'(g_q);
        end
      end
      ldps_pkg::ST_GCD_CHK: begin
        div_start = 1'b1;
        if (q_q == '0) begin
          div_dividend = ldps_pkg::DivW'(coef_y_i);
          div_divisor  = DVW'(p_q);
        end else begin
          div_dividend = ldps_pkg::DivW'(p_q);
          div_divisor  = DVW'(q_q);
        end
      end
      ldps_pkg::ST_DIV_B: begin
        if (div_done && !(div_quo > MaxMod)) begin
          div_start    = 1'b1;
          div_dividend = ldps_pkg::DivW'(coef_x_i);
          div_divisor  = DVW'(g_q);
        end
      end
      ldps_pkg::ST_DIV_A: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = div_quo;
          div_divisor  = DVW'(b_q);
        end
      end
      ldps_pkg::ST_FILL: ram_we = 1'b1;
      ldps_pkg::ST_DIV_C: begin
        if (div_done && div_rem == '0) begin
          div_start    = 1'b1;
          div_dividend = div_quo;
          div_divisor  = DVW'(b_q);
        end
      end
      ldps_pkg::ST_SUB: begin
        if (!(diff[CW-1] || diff == '0)) begin
          div_start    = 1'b1;
          div_dividend = ldps_pkg::DivW'(diff);
          div_divisor  = DVW'(b_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ldps_pkg::ST_IDLE;
      prepared_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      g_q          <= '0;
      a_q          <= '0;
      b_q          <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ldps_pkg::ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ldps_pkg::ST_IDLE: begin
          if (q_valid_i && q_head_i.cls == ldps_pkg::CLS_PREP_BAD) begin
            prepared_q <= 1'b0;
          end
        end
        ldps_pkg::ST_GCD_CHK: if (q_q == '0) g_q <= p_q;
        ldps_pkg::ST_DIV_B: begin
          if (div_done) begin
            if (div_quo > MaxMod) begin
              prepared_q <= 1'b0;
            end
            b_q <= div_quo[BW-1:0];
          end
        end
        ldps_pkg::ST_DIV_A: if (div_done) a_q <= div_quo[ldps_pkg::CoefW-1:0];
        ldps_pkg::ST_FILL:  if (i_q == b_q) prepared_q <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ldps_pkg::ST_IDLE: begin
        p_q          <= coef_x_i;
        q_q          <= coef_y_i;
        rs_q         <= '0;
        ss_q         <= '0;
        if (q_head_i.cls == ldps_pkg::CLS_SOLVE) begin
          res_status_q <= prepared_q ? ldps_pkg::STATUS_OK : ldps_pkg::STATUS_NOT_PREPARED;
        end else if (q_head_i.cls == ldps_pkg::CLS_PREP_BAD) begin
          res_status_q <= ldps_pkg::STATUS_TOO_LARGE;
        end else begin
          res_status_q <= ldps_pkg::STATUS_OK;
        end
      end
      ldps_pkg::ST_GCD_DIV: begin
        if (div_done) begin
          p_q <= q_q;
          q_q <= div_rem[ldps_pkg::CoefW-1:0];
        end
      end
      ldps_pkg::ST_DIV_B: begin
        if (div_done && div_quo > MaxMod) begin
          res_status_q <= ldps_pkg::STATUS_TOO_LARGE;
        end
      end
      ldps_pkg::ST_DIV_AM: begin
        if (div_done) begin
          step_q <= div_rem[BW-1:0];
          res_q  <= div_rem[AW-1:0];
          i_q    <= BW'(1);
        end
      end
      ldps_pkg::ST_FILL: begin
        i_q <= i_q + 1'b1;
        // Next residue is the current one plus A mod B, wrapped once.
        if (res_sum >= {1'b0, b_q}) begin
          res_q <= AW'(res_sum - {1'b0, b_q});
        end else begin
          res_q <= AW'(res_sum);
        end
      end
      ldps_pkg::ST_DIV_C: begin
        if (div_done) begin
          c_q <= div_quo[ldps_pkg::AmountW-1:0];
          if (div_rem != '0) begin
            res_status_q <= ldps_pkg::STATUS_NO_SOLUTION;
          end
        end
      end
      ldps_pkg::ST_DIV_IDX: if (div_done) rd_addr_q <= div_rem[AW-1:0];
      ldps_pkg::ST_AR: begin
        r_q    <= ram_rdata;
        prod_q <= a_q * ram_rdata;
      end
      ldps_pkg::ST_SUB: begin
        if (diff[CW-1] || diff == '0) begin
          res_status_q <= ldps_pkg::STATUS_NO_SOLUTION;
        end
      end
      ldps_pkg::ST_DIV_S: if (div_done) s_q <= div_quo[ldps_pkg::AmountW-1:0];
      ldps_pkg::ST_SCL: begin
        rs_q <= ldps_pkg::RValW'(r_scaled);
        ss_q <= ldps_pkg::SValW'(s_scaled);
      end
      ldps_pkg::ST_OUT: begin
        if (out_free) begin
          status_out_q <= res_status_q;
          r_out_q      <= rs_q;
          s_out_q      <= ss_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_out_q;
  assign r_value_o   = r_out_q;
  assign s_value_o   = s_out_q;

endmodule
`default_nettype wire

// ===== sv/linear_diophantine_positive_solver.sv =====
// Top level of the positive linear Diophantine solver.
// Solve: from queue head to result, three divisions on the shared divider, a table read and a scaling.
// Prepare: one division per Euclid step, then three divisions, then a fill that writes B table entries.
// Items are processed one at a time; a two-entry queue and the output register decouple ports.
// Reset is asynchronous, active low; it clears control state and the prepared flag.
// The residue table is not cleared; a successful prepare writes every entry that a solve reads.
`default_nettype none
module linear_diophantine_positive_solver #(
  parameter int unsigned MAX_MODULUS = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [ldps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [ldps_pkg::ScaleW-1:0]    cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           cmd_i,
  input  wire logic [ldps_pkg::AmountW-1:0]   amount_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [1:0]                     status_o,
  output logic      [ldps_pkg::RValW-1:0]     r_value_o,
  output logic      [ldps_pkg::SValW-1:0]     s_value_o
);

  logic [ldps_pkg::CoefW-1:0]  coef_x_q, coef_y_q;
  logic [ldps_pkg::ScaleW-1:0] scale_q;
  logic                        q_valid, q_pop;
  ldps_pkg::q_entry_t          q_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_x_q <= ldps_pkg::CoefW'(1);
      coef_y_q <= ldps_pkg::CoefW'(1);
      scale_q  <= ldps_pkg::ScaleW'(1000);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ldps_pkg::REG_COEF_X: coef_x_q <= cfg_wdata_i[ldps_pkg::CoefW-1:0];
        ldps_pkg::REG_COEF_Y: coef_y_q <= cfg_wdata_i[ldps_pkg::CoefW-1:0];
        ldps_pkg::REG_SCALE:  scale_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  ldps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .amount_i   (amount_i),
    .coef_x_i   (coef_x_q),
    .coef_y_i   (coef_y_q),
    .q_valid_o  (q_valid),
    .q_head_o   (q_head),
    .q_pop_i    (q_pop)
  );

  ldps_back #(.MAX_MODULUS(MAX_MODULUS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .coef_x_i    (coef_x_q),
    .coef_y_i    (coef_y_q),
    .scale_i     (scale_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .r_value_o   (r_value_o),
    .s_value_o   (s_value_o)
  );

endmodule
`default_nettype wire

// ===== sv/ldps_checker.sv =====
// Port-level checks for the solver, bound to the top level.
`default_nettype none
module ldps_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [1:0]                   status_o,
  input wire logic [ldps_pkg::RValW-1:0]   r_value_o,
  input wire logic [ldps_pkg::SValW-1:0]   s_value_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before transaction");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(status_o) && $stable(r_value_o)
      && $stable(s_value_o))
    else $error("result payload changed while stalled");

  // Any status other than ok carries zero values.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ldps_pkg::STATUS_OK |-> r_value_o == '0 && s_value_o == '0)
    else $error("non-zero values on a failed transaction");

  // No result straight out of reset.
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result offered right after reset");

endmodule

bind linear_diophantine_positive_solver ldps_checker u_ldps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .r_value_o   (r_value_o),
  .s_value_o   (s_value_o)
);
`default_nettype wire

// ===== verif/ldps_checker.sv =====
// Checker for the positive linear Diophantine solver: predicts each result and compares it.
`timescale 1ns / 1ps
module ldps_scoreboard (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ldps_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ldps_pkg::ScaleW-1:0]  cfg_wdata_i,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_ready_i,
  input  wire logic                         cmd_i,
  input  wire logic [ldps_pkg::AmountW-1:0] amount_i,
  input  wire logic                         out_valid_i,
  input  wire logic                         out_ready_i,
  input  wire logic [1:0]                   status_i,
  input  wire logic [ldps_pkg::RValW-1:0]   r_value_i,
  input  wire logic [ldps_pkg::SValW-1:0]   s_value_i,
  output int                                pending_o,
  output int                                errors_o
);

  localparam int unsigned TableDepth = 1024;

  typedef struct {
    ldps_pkg::status_e            status;
    logic [ldps_pkg::RValW-1:0]   r_val;
    logic [ldps_pkg::SValW-1:0]   s_val;
  } answer_t;

  answer_t answer_q[$];

  logic [ldps_pkg::CoefW-1:0]  coef_x;
  logic [ldps_pkg::CoefW-1:0]  coef_y;
  logic [ldps_pkg::ScaleW-1:0] scale;
  int unsigned       div_g;
  int unsigned       red_a;
  int unsigned       red_b;
  int unsigned       mult_of_residue[TableDepth];
  bit                is_prepared;

  function automatic int unsigned euclid(input int unsigned p, input int unsigned q);
    int unsigned t;
    while (q != 0) begin
      t = p % q;
      p = q;
      q = t;
    end
    return p;
  endfunction

  function void solve_item(input logic cmd, input logic [ldps_pkg::AmountW-1:0] amt);
    answer_t     ans;
    int unsigned g;
    int unsigned b;
    longint      c;
    longint      r;
    longint      s;
    logic [63:0] prod;
    ans.status = ldps_pkg::STATUS_OK;
    ans.r_val  = '0;
    ans.s_val  = '0;
    if (cmd == ldps_pkg::CMD_PREPARE) begin
      if (coef_x == 0 || coef_y == 0) begin
        is_prepared = 1'b0;
        ans.status  = ldps_pkg::STATUS_TOO_LARGE;
      end else begin
        g = euclid(coef_x, coef_y);
        b = coef_y / g;
        if (b > TableDepth) begin
          is_prepared = 1'b0;
          ans.status  = ldps_pkg::STATUS_TOO_LARGE;
        end else begin
          div_g = g;
          red_a = coef_x / g;
          red_b = b;
          for (int unsigned i = 1; i <= b; i++) begin
            mult_of_residue[(longint'(red_a) * i) % b] = i;
          end
          is_prepared = 1'b1;
        end
      end
    end else if (!is_prepared || div_g == 0 || red_b == 0) begin
      ans.status = ldps_pkg::STATUS_NOT_PREPARED;
    end else if (amt % div_g != 0) begin
      ans.status = ldps_pkg::STATUS_NO_SOLUTION;
    end else begin
      c = longint'(amt) / div_g;
      r = mult_of_residue[c % red_b];
      s = (c - longint'(red_a) * r) / longint'(red_b);
      if (s <= 0) begin
        ans.status = ldps_pkg::STATUS_NO_SOLUTION;
      end else begin
        prod      = 64'(r) * 64'(scale);
        ans.r_val = prod[ldps_pkg::RValW-1:0];
        prod      = 64'(s) * 64'(scale);
        ans.s_val = prod[ldps_pkg::SValW-1:0];
      end
    end
    answer_q.push_back(ans);
  endfunction

  initial errors_o = 0;
  initial pending_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      answer_q.delete();
      coef_x      = 16'd1;
      coef_y      = 16'd1;
      scale       = 20'd1000;
      div_g       = 0;
      red_a       = 0;
      red_b       = 0;
      is_prepared = 1'b0;
      pending_o  <= 0;
    end else begin
      // Results are taken first: a result leaving now cannot belong to an item entering now.
      if (out_valid_i && out_ready_i) begin
        if (answer_q.size() == 0) begin
          errors_o = errors_o + 1;
          if (errors_o <= 10) begin
            $display("%0t: unexpected result status=%0d r=%0d s=%0d", $realtime, status_i,
                     r_value_i, s_value_i);
          end
        end else begin
          want = answer_q.pop_front();
          if (status_i !== want.status || r_value_i !== want.r_val ||
              s_value_i !== want.s_val) begin
            errors_o = errors_o + 1;
            if (errors_o <= 10) begin
              $display("%0t: mismatch: expected status=%0d r=%0d s=%0d, got status=%0d r=%0d s=%0d",
                       $realtime, want.status, want.r_val, want.s_val, status_i, r_value_i,
                       s_value_i);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        solve_item(cmd_i, amount_i);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ldps_pkg::REG_COEF_X: begin
            coef_x = cfg_wdata_i[ldps_pkg::CoefW-1:0];
          end
          ldps_pkg::REG_COEF_Y: begin
            coef_y = cfg_wdata_i[ldps_pkg::CoefW-1:0];
          end
          ldps_pkg::REG_SCALE: begin
            scale = cfg_wdata_i;
          end
          default: begin
          end
        endcase
      end
      pending_o <= answer_q.size();
    end
  end

endmodule

// ===== verif/tb_linear_diophantine_positive_solver.sv =====
// Testbench top for the positive linear Diophantine solver: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_linear_diophantine_positive_solver;

  localparam int IdleLimit = 20000;
  localparam int Phases    = 12;
  localparam int PhaseLen  = 45;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [ldps_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [ldps_pkg::ScaleW-1:0]  cfg_wdata_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic                         cmd_i;
  logic [ldps_pkg::AmountW-1:0] amount_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [1:0]                   status_o;
  logic [ldps_pkg::RValW-1:0]   r_value_o;
  logic [ldps_pkg::SValW-1:0]   s_value_o;
  int                           pending;
  int                           errors;

  bit          no_idle;
  bit          hold_request;
  int unsigned cur_g;
  int unsigned cur_a;
  int unsigned cur_b;

  linear_diophantine_positive_solver uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .cmd_i, .amount_i, .out_valid_o, .out_ready_i, .status_o, .r_value_o, .s_value_o
  );

  ldps_scoreboard u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .in_valid_i,
    .in_ready_i(in_ready_o), .cmd_i, .amount_i, .out_valid_i(out_valid_o), .out_ready_i,
    .status_i(status_o), .r_value_i(r_value_o), .s_value_i(s_value_o),
    .pending_o(pending), .errors_o(errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  function automatic int unsigned common_div(input int unsigned p, input int unsigned q);
    int unsigned t;
    while (q != 0) begin
      t = p % q;
      p = q;
      q = t;
    end
    return p;
  endfunction

  // Mostly multiples of g, some small enough that s turns out zero or negative.
  function automatic logic [ldps_pkg::AmountW-1:0] pick_amount();
    int          sel;
    longint      kmax;
    longint      klim;
    sel = $urandom_range(0, 9);
    if (sel < 3 || cur_g == 0) return ldps_pkg::AmountW'($urandom);
    kmax = 64'h7FFF_FFFF / cur_g;
    klim = kmax;
    if (sel >= 6 && 4 * longint'(cur_a) * cur_b + 8 < kmax) klim = 4 * longint'(cur_a) * cur_b + 8;
    return ldps_pkg::AmountW'(cur_g * longint'($urandom_range(0, 32'(klim))));
  endfunction

  task automatic send(input logic cmd, input logic [ldps_pkg::AmountW-1:0] amt);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    amount_i   <= amt;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Waits for a clock edge before reading the count, so that it already includes the item taken last.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_regs(input int unsigned x, input int unsigned y,
                            input logic [ldps_pkg::ScaleW-1:0] sc);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= ldps_pkg::REG_COEF_X;
    cfg_wdata_i <= ldps_pkg::ScaleW'(x);
    @(posedge clk_i);
    cfg_idx_i   <= ldps_pkg::REG_COEF_Y;
    cfg_wdata_i <= ldps_pkg::ScaleW'(y);
    @(posedge clk_i);
    cfg_idx_i   <= ldps_pkg::REG_SCALE;
    cfg_wdata_i <= sc;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (x != 0 && y != 0) begin
      cur_g = common_div(x, y);
      cur_a = x / cur_g;
      cur_b = y / cur_g;
    end else begin
      cur_g = 0;
    end
  endtask

  // Receiver: random stalls, plus one long hold-off so that the block backs up.
  initial begin
    int gap_left;
    int hold_left;
    gap_left    = 0;
    hold_left   = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 600;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        out_ready_i <= 1'b0;
        gap_left--;
      end else begin
        out_ready_i <= 1'b1;
        gap_left = no_idle ? 0 : pick_gap();
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int unsigned x;
    int unsigned y;
    int unsigned g;
    int unsigned b;
    int          sel;
    logic [ldps_pkg::ScaleW-1:0] sc;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = ldps_pkg::REG_COEF_X;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    cmd_i        = ldps_pkg::CMD_PREPARE;
    amount_i     = '0;
    no_idle      = 1'b0;
    hold_request = 1'b0;
    cur_g = 1; cur_a = 1; cur_b = 1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: solve before any prepare, then the reset coefficients.
    send(ldps_pkg::CMD_SOLVE, 31'd123);
    send(ldps_pkg::CMD_PREPARE, '0);
    send(ldps_pkg::CMD_SOLVE, 31'd0);
    send(ldps_pkg::CMD_SOLVE, 31'd5);
    send(ldps_pkg::CMD_SOLVE, 31'h7FFF_FFFF);
    settle();
    // A zero coefficient fails the prepare, so the following solve is not prepared.
    write_regs(0, 7, 20'd1);
    send(ldps_pkg::CMD_PREPARE, 31'h7FFF_FFFF);
    send(ldps_pkg::CMD_SOLVE, 31'd10);
    settle();
    write_regs(65535, 65535, 20'hFFFFF);
    send(ldps_pkg::CMD_PREPARE, '0);
    send(ldps_pkg::CMD_SOLVE, 31'h7FFF_FFFF);
    send(ldps_pkg::CMD_SOLVE, 31'(65535 * 3));
    settle();
    write_regs(1, 65535, 20'd1000);
    send(ldps_pkg::CMD_PREPARE, '0);
    send(ldps_pkg::CMD_SOLVE, 31'd77);
    settle();
    // Largest modulus that fits the table, with a scale of zero.
    write_regs(3, 1024, 20'd0);
    send(ldps_pkg::CMD_PREPARE, '0);
    send(ldps_pkg::CMD_SOLVE, 31'd5000);
    send(ldps_pkg::CMD_SOLVE, 31'h7FFF_FFFF);
    send(ldps_pkg::CMD_SOLVE, 31'd0);
    settle();
    write_regs(65535, 0, 20'd1);
    send(ldps_pkg::CMD_PREPARE, '0);
    send(ldps_pkg::CMD_SOLVE, 31'd9);
    settle();

    for (int ph = 0; ph < Phases; ph++) begin
      sel = $urandom_range(0, 9);
      b   = (sel < 7) ? $urandom_range(1, 64) : $urandom_range(65, 1024);
      g   = $urandom_range(1, 65535 / b);
      x   = g * $urandom_range(1, 65535 / g);
      y   = g * b;
      if (sel == 8) y = $urandom_range(1, 65535);
      if (sel == 9 && ph % 3 == 0) x = 0;
      case ($urandom_range(0, 4))
        0: sc = 20'd0;
        1: sc = 20'd1;
        2: sc = 20'd1000;
        3: sc = 20'hFFFFF;
        default: sc = ldps_pkg::ScaleW'($urandom);
      endcase
      no_idle = (ph % 4 == 1);
      write_regs(x, y, sc);
      send(ldps_pkg::CMD_PREPARE, ldps_pkg::AmountW'($urandom));
      for (int n = 1; n < PhaseLen; n++) begin
        if (ph == 2 && n == 5) hold_request = 1'b1;
        if ($urandom_range(0, 99) < 8) send(ldps_pkg::CMD_PREPARE, ldps_pkg::AmountW'($urandom));
        else send(ldps_pkg::CMD_SOLVE, pick_amount());
      end
      settle();
    end

    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
